// ----- src/bounded_ordered_list_engine_assert.svh -----
// assertion macros for the ordered list engine checker
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BOLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bole_pkg.sv -----
// shared types and constants of the ordered list engine
package bole_pkg;

  localparam int DEPTH     = 16;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 4;
  localparam int INDEX_W   = 4;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 5;
  localparam int IDX_CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_AFTER = 4'd0,
    CMD_ERASE        = 4'd1,
    CMD_PUSH_FRONT   = 4'd2,
    CMD_PUSH_BACK    = 4'd3,
    CMD_POP_FRONT    = 4'd4,
    CMD_POP_BACK     = 4'd5,
    CMD_SORT         = 4'd6,
    CMD_CLEAR        = 4'd7,
    CMD_READ         = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [DATA_W-1:0]  key;
    logic signed [DATA_W-1:0]  value;
    logic [INDEX_W-1:0]        index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctrl_stat_t;

endpackage

// ----- src/bole_ram.sv -----
// simple dual-port ram, one write and one registered read per cycle
module bole_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bole_ctrl.sv -----
// command sequencer: walks, shifts and sorts the entry ram
module bole_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  bole_pkg::in_item_t              item,
  input  logic                            res_free,
  input  logic [bole_pkg::DATA_W-1:0]     mem_rdata,
  output bole_pkg::mem_req_t              mem_req,
  output bole_pkg::ctrl_stat_t            stat,
  output bole_pkg::out_item_t             res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_PUT,
    S_SORT,
    S_SORTEND,
    S_RDW,
    S_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  logic [bole_pkg::CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [bole_pkg::DATA_W-1:0]     key_r, key_nxt;
  logic [bole_pkg::DATA_W-1:0]     val_r, val_nxt;
  logic [bole_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [bole_pkg::CNT_W-1:0]      rem_r, rem_nxt;
  logic [bole_pkg::CNT_W-1:0]      len_r, len_nxt;
  logic [bole_pkg::AW-1:0]         ptr_r, ptr_nxt;
  logic [bole_pkg::AW-1:0]         tag_r, tag_nxt;
  logic [bole_pkg::AW-1:0]         pos_r, pos_nxt;
  logic                            pend_r, pend_nxt;
  logic [bole_pkg::DATA_W-1:0]     carry_r, carry_nxt;
  logic [bole_pkg::DATA_W-1:0]     rdata_r, rdata_nxt;
  bole_pkg::status_t               status_r, status_nxt;

  logic [bole_pkg::DATA_W-1:0]     target;
  logic                            hit;
  logic                            full;
  logic                            empty;
  logic                            idx_ok;

  assign target = (cmd_r == bole_pkg::CMD_ERASE) ? val_r : key_r;
  assign hit    = pend_r && (mem_rdata == target);
  assign full   = (cnt_r == bole_pkg::CNT_W'(bole_pkg::DEPTH));
  assign empty  = (cnt_r == '0);
  assign idx_ok = (bole_pkg::IDX_CMP_W'(item.index) < bole_pkg::IDX_CMP_W'(cnt_r)) &&
                  (bole_pkg::IDX_CMP_W'(item.index) <
                   bole_pkg::IDX_CMP_W'(bole_pkg::DEPTH));

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    len_nxt    = len_r;
    ptr_nxt    = ptr_r;
    tag_nxt    = tag_r;
    pos_nxt    = pos_r;
    pend_nxt   = 1'b0;
    carry_nxt  = carry_r;
    rdata_nxt  = rdata_r;
    status_nxt = status_r;

    mem_req.we    = 1'b0;
    mem_req.waddr = tag_r;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = ptr_r;

    stat.idle = (state_r == S_IDLE);
    stat.done = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = item.command;
          key_nxt    = item.key;
          val_nxt    = item.value;
          rdata_nxt  = '0;
          status_nxt = bole_pkg::ST_OK;
          state_nxt  = S_FIN;
          case (item.command)
            bole_pkg::CMD_INSERT_AFTER: begin
              if (full) begin
                status_nxt = bole_pkg::ST_FULL;
              end else if (empty) begin
                status_nxt = bole_pkg::ST_EMPTY;
              end else begin
                ptr_nxt   = '0;
                rem_nxt   = cnt_r;
                state_nxt = S_SCAN;
              end
            end
            bole_pkg::CMD_ERASE: begin
              if (empty) begin
                status_nxt = bole_pkg::ST_EMPTY;
              end else begin
                ptr_nxt   = '0;
                rem_nxt   = cnt_r;
                state_nxt = S_SCAN;
              end
            end
            bole_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                status_nxt = bole_pkg::ST_FULL;
              end else begin
                pos_nxt   = '0;
                ptr_nxt   = bole_pkg::AW'(cnt_r - 1'b1);
                rem_nxt   = cnt_r;
                state_nxt = S_SHUP;
              end
            end
            bole_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                status_nxt = bole_pkg::ST_FULL;
              end else begin
                pos_nxt   = bole_pkg::AW'(cnt_r);
                state_nxt = S_PUT;
              end
            end
            bole_pkg::CMD_POP_FRONT: begin
              if (empty) begin
                status_nxt = bole_pkg::ST_EMPTY;
              end else begin
                ptr_nxt   = bole_pkg::AW'(1);
                rem_nxt   = cnt_r - 1'b1;
                state_nxt = S_SHDN;
              end
            end
            bole_pkg::CMD_POP_BACK: begin
              if (empty) begin
                status_nxt = bole_pkg::ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            bole_pkg::CMD_SORT: begin
              if (empty) begin
                status_nxt = bole_pkg::ST_EMPTY;
              end else if (cnt_r > bole_pkg::CNT_W'(1)) begin
                len_nxt   = cnt_r;
                ptr_nxt   = '0;
                rem_nxt   = cnt_r;
                state_nxt = S_SORT;
              end
            end
            bole_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            bole_pkg::CMD_READ: begin
              if (idx_ok) begin
                mem_req.raddr = bole_pkg::AW'(item.index);
                state_nxt     = S_RDW;
              end else begin
                status_nxt = bole_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // linear search, compare made in the cycle after the read
      S_SCAN: begin
        if (hit) begin
          rem_nxt = bole_pkg::CNT_W'(cnt_r - bole_pkg::CNT_W'(tag_r) - 1'b1);
          if (cmd_r == bole_pkg::CMD_INSERT_AFTER) begin
            pos_nxt   = bole_pkg::AW'(tag_r + 1'b1);
            ptr_nxt   = bole_pkg::AW'(cnt_r - 1'b1);
            state_nxt = S_SHUP;
          end else begin
            ptr_nxt   = bole_pkg::AW'(tag_r + 1'b1);
            state_nxt = S_SHDN;
          end
        end else if (rem_r != '0) begin
          mem_req.raddr = ptr_r;
          ptr_nxt       = ptr_r + 1'b1;
          rem_nxt       = rem_r - 1'b1;
          tag_nxt       = ptr_r;
          pend_nxt      = 1'b1;
        end else if (!pend_r) begin
          status_nxt = bole_pkg::ST_NOTFOUND;
          state_nxt  = S_FIN;
        end
      end

      // open a gap: copy entries one place up, top first
      S_SHUP: begin
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = bole_pkg::AW'(tag_r + 1'b1);
          mem_req.wdata = mem_rdata;
        end
        if (rem_r != '0) begin
          mem_req.raddr = ptr_r;
          ptr_nxt       = ptr_r - 1'b1;
          rem_nxt       = rem_r - 1'b1;
          tag_nxt       = ptr_r;
          pend_nxt      = 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = val_r;
        cnt_nxt       = cnt_r + 1'b1;
        state_nxt     = S_FIN;
      end

      // close a gap: copy entries one place down, bottom first
      S_SHDN: begin
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = bole_pkg::AW'(tag_r - 1'b1);
          mem_req.wdata = mem_rdata;
        end
        if (rem_r != '0) begin
          mem_req.raddr = ptr_r;
          ptr_nxt       = ptr_r + 1'b1;
          rem_nxt       = rem_r - 1'b1;
          tag_nxt       = ptr_r;
          pend_nxt      = 1'b1;
        end else if (!pend_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_FIN;
        end
      end

      // one bubble pass: carry holds the largest entry seen so far
      S_SORT: begin
        if (pend_r) begin
          if (tag_r == '0) begin
            carry_nxt = mem_rdata;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = bole_pkg::AW'(tag_r - 1'b1);
            if ($signed(carry_r) > $signed(mem_rdata)) begin
              mem_req.wdata = mem_rdata;
            end else begin
              mem_req.wdata = carry_r;
              carry_nxt     = mem_rdata;
            end
          end
        end
        if (rem_r != '0) begin
          mem_req.raddr = ptr_r;
          ptr_nxt       = ptr_r + 1'b1;
          rem_nxt       = rem_r - 1'b1;
          tag_nxt       = ptr_r;
          pend_nxt      = 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_SORTEND;
        end
      end

      S_SORTEND: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = bole_pkg::AW'(len_r - 1'b1);
        mem_req.wdata = carry_r;
        len_nxt       = len_r - 1'b1;
        if (len_r > bole_pkg::CNT_W'(2)) begin
          ptr_nxt   = '0;
          rem_nxt   = len_r - 1'b1;
          state_nxt = S_SORT;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_RDW: begin
        rdata_nxt = mem_rdata;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        stat.done = res_free;
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    rem_r    <= rem_nxt;
    len_r    <= len_nxt;
    ptr_r    <= ptr_nxt;
    tag_r    <= tag_nxt;
    pos_r    <= pos_nxt;
    carry_r  <= carry_nxt;
    rdata_r  <= rdata_nxt;
    status_r <= status_nxt;
  end

  assign res.status    = status_r;
  assign res.read_data = rdata_r;
  assign res.count     = bole_pkg::COUNT_W'(cnt_r);
  assign res.is_empty  = (cnt_r == '0);

endmodule

// ----- src/bounded_ordered_list_engine.sv -----
// clear, pop_back and early error returns finish without touching the entry ram
// push_back writes one entry and read reads one; push_front, pop_front, insert and erase shift entries
// insert searches for the key and erase for the value; a key or value that is absent returns not found
// sort runs bubble passes, the pass length running from count down to 2
// one item at a time over the single entry ram port pair; a stalled result holds the input
// reset clears the count and the control state; the entry ram is not cleared and needs no clearing pass
module bounded_ordered_list_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bole_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bole_pkg::out_item_t  out_data
);

  bole_pkg::mem_req_t          mem_req;
  logic [bole_pkg::DATA_W-1:0] mem_rdata;
  bole_pkg::ctrl_stat_t        stat;
  bole_pkg::out_item_t         res;
  logic                        start;
  logic                        res_free;

  logic                        out_valid_r, out_valid_nxt;
  bole_pkg::out_item_t         out_data_r, out_data_nxt;

  // input transfer only while the sequencer is idle
  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;

  // result register is free when empty or being drained this cycle
  assign res_free = !out_valid_r || out_ready;

  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (in_data),
    .res_free  (res_free),
    .mem_rdata (mem_rdata),
    .mem_req   (mem_req),
    .stat      (stat),
    .res       (res)
  );

  // entry store, front of the list at address zero
  bole_ram #(
    .ADDR_W (bole_pkg::AW),
    .DATA_W (bole_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // output register parts the result side from the sequencer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (stat.done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/bole_checker.sv -----
// port-level checker for the ordered list engine, bound to the top level
`include "bounded_ordered_list_engine_assert.svh"

module bole_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bole_pkg::out_item_t out_data
);

  logic cnt_zero;
  logic out_err;
  logic out_stall;

  assign cnt_zero  = (out_data.count == '0);
  assign out_err   = out_valid && (out_data.status != bole_pkg::ST_OK);
  assign out_stall = out_valid && !out_ready;

  // empty flag agrees with the count
  `BOLE_ASSERT_NOW(a_empty_flag, out_valid, out_data.is_empty == cnt_zero, "bad empty flag")

  // only a successful read returns data
  `BOLE_ASSERT_NOW(a_rdata_zero, out_err, out_data.read_data == '0, "data on error status")

  // one item at a time: busy right after an input transfer
  `BOLE_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after transfer")

  // a stalled result holds
  `BOLE_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result changed")

endmodule

bind bounded_ordered_list_engine bole_checker u_chk (.*);
